// File: sv/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Clocked assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define TCW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCW_ASSERT_ALWAYS(label, expr, msg)
`define TCW_ASSERT_IMPLIES(label, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLS  = 80;
    localparam int DEF_ROWS  = 25;

    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'b1;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ERROR   = 8'd69;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PRINT = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_CLEAR
    } state_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_CHAR,
        MEM_ERR,
        MEM_RD_CELL,
        MEM_RD_SWEEP,
        MEM_WR_COPY,
        MEM_WR_ZERO,
        MEM_WR_BLANK
    } mem_op_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_SET_COPY,
        IDX_SET_FILL,
        IDX_INC
    } idx_op_t;

    typedef struct packed {
        logic    load;
        mem_op_t mem_op;
        idx_op_t idx_op;
        logic    upd_cursor;
        logic    home;
        logic    emit;
        logic    emit_err;
        logic    emit_read;
        logic    emit_scr;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  bad;
        logic  newline;
        logic  need_scroll;
        logic  sweep_last;
    } dp_status_t;

endpackage

// File: sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences prints, reads, scroll copies and clear sweeps over the datapath.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tcw_pkg::dp_status_t    status,
    output tcw_pkg::ctrl_cmd_t     cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.func)
                    FUNC_PRINT:
                    begin
                        if (status.bad)
                        begin
                            cmd.mem_op   = MEM_ERR;
                            cmd.emit     = 1'b1;
                            cmd.emit_err = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            cmd.mem_op     = status.newline ? MEM_NONE : MEM_CHAR;
                            cmd.upd_cursor = 1'b1;
                            if (status.need_scroll)
                            begin
                                cmd.idx_op = IDX_SET_COPY;
                                state_next = ST_SCROLL_RD;
                            end
                            else
                            begin
                                cmd.emit   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = ST_CLEAR;
                    end
                    FUNC_READ:
                    begin
                        if (status.bad)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_err = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            cmd.mem_op = MEM_RD_CELL;
                            state_next = ST_READ;
                        end
                    end
                    FUNC_NONE:
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_read = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCROLL_RD:
            begin
                cmd.mem_op = MEM_RD_SWEEP;
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                cmd.mem_op = MEM_WR_COPY;
                if (status.sweep_last)
                begin
                    cmd.idx_op = IDX_SET_FILL;
                    state_next = ST_FILL;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = ST_SCROLL_RD;
                end
            end
            ST_FILL:
            begin
                cmd.mem_op = MEM_WR_ZERO;
                if (status.sweep_last)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_scr = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            ST_CLEAR:
            begin
                cmd.mem_op = MEM_WR_BLANK;
                if (status.sweep_last)
                begin
                    cmd.home   = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `TCW_ASSERT_NEXT(a_emit_returns_idle, cmd.emit, state_reg == ST_IDLE, "emit not followed by idle")
    `TCW_ASSERT_IMPLIES(a_copy_after_read, state_reg == ST_SCROLL_WR, $past(state_reg) == ST_SCROLL_RD, "copy write without read")
    `TCW_ASSERT_IMPLIES(a_idle_no_store_op, !busy, cmd.mem_op == MEM_NONE && !cmd.emit, "store op while idle")
    `TCW_ASSERT_IMPLIES(a_scroll_flag_on_fill, cmd.emit_scr, state_reg == ST_FILL && status.sweep_last, "scroll flag outside fill end")

endmodule

// File: sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell store, cursor, configuration registers, sweep index and result registers.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tcw_pkg::FUNC_W-1:0]        func,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]        attr,
    input  logic [tcw_pkg::COL_W-1:0]         col,
    input  logic [tcw_pkg::ROW_W-1:0]         row,
    input  logic                              use_cursor,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [tcw_pkg::CFG_W-1:0]         cfg_wdata,
    input  tcw_pkg::ctrl_cmd_t                cmd,
    output tcw_pkg::dp_status_t               status,
    output logic                              done,
    output logic [tcw_pkg::COL_W-1:0]         next_col,
    output logic [tcw_pkg::ROW_W-1:0]         next_row,
    output logic                              coord_error,
    output logic                              scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]        cell_attr
);
    import tcw_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLS);
    localparam logic [ROW_W-1:0]  ROWS_C    = ROW_W'(ROWS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] FILL_BASE = ADDR_W'(CELLS - COLS);

    // request registers
    func_t               func_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [ATTR_W-1:0]   attr_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                usec_reg;

    logic [ATTR_W-1:0]   default_attr_reg;
    logic [ATTR_W-1:0]   error_attr_reg;

    logic [COL_W-1:0]    cursor_col_reg;
    logic [COL_W-1:0]    cursor_col_next;
    logic [ROW_W-1:0]    cursor_row_reg;
    logic [ROW_W-1:0]    cursor_row_next;

    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   idx_next;

    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   mem_rdata_reg;

    logic                done_reg;
    logic [COL_W-1:0]    next_col_reg;
    logic [ROW_W-1:0]    next_row_reg;
    logic                coord_error_reg;
    logic                scrolled_reg;
    logic [CHAR_W-1:0]   cell_char_reg;
    logic [ATTR_W-1:0]   cell_attr_reg;

    logic [COL_W-1:0]    base_col;
    logic [ROW_W-1:0]    base_row;
    logic [ADDR_W-1:0]   pos;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_W-1:0]    adv_row;
    logic                wrap;
    logic                bad;
    logic [ATTR_W-1:0]   attr_eff;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            char_reg <= char_code;
            attr_reg <= attr;
            col_reg  <= col;
            row_reg  <= row;
            usec_reg <= use_cursor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= DEFAULT_ATTR_RST;
            error_attr_reg   <= ERROR_ATTR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DEFAULT_ATTR: default_attr_reg <= cfg_wdata;
                CFG_ERROR_ATTR:   error_attr_reg   <= cfg_wdata;
                default:          default_attr_reg <= default_attr_reg;
            endcase
        end
    end

    assign bad      = !usec_reg && ((col_reg >= COLS_C) || (row_reg >= ROWS_C));
    assign base_col = usec_reg ? cursor_col_reg : col_reg;
    assign base_row = usec_reg ? cursor_row_reg : row_reg;
    assign pos      = ADDR_W'(base_row) * COLS_A + ADDR_W'(base_col);
    assign attr_eff = (attr_reg == '0) ? default_attr_reg : attr_reg;

    always_comb
    begin
        wrap    = (char_reg == CH_NEWLINE) || (base_col == LAST_COL);
        adv_col = wrap ? '0 : base_col + COL_W'(1);
        adv_row = wrap ? base_row + ROW_W'(1) : base_row;
    end

    assign status.func        = func_reg;
    assign status.bad         = bad;
    assign status.newline     = (char_reg == CH_NEWLINE);
    assign status.need_scroll = wrap && (base_row == LAST_ROW);
    assign status.sweep_last  = (idx_reg == LAST_CELL);

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (cmd.home)
        begin
            cursor_col_next = '0;
            cursor_row_next = '0;
        end
        else if (cmd.upd_cursor)
        begin
            cursor_col_next = adv_col;
            cursor_row_next = status.need_scroll ? LAST_ROW : adv_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_HOLD:     idx_next = idx_reg;
            IDX_ZERO:     idx_next = '0;
            IDX_SET_COPY: idx_next = COLS_A;
            IDX_SET_FILL: idx_next = FILL_BASE;
            IDX_INC:      idx_next = idx_reg + ADDR_W'(1);
            default:      idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = idx_reg;
        unique case (cmd.mem_op)
            MEM_NONE:
            begin
                mem_we = 1'b0;
            end
            MEM_CHAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos;
                mem_wdata = {attr_eff, char_reg};
            end
            MEM_ERR:
            begin
                mem_we    = 1'b1;
                mem_waddr = LAST_CELL;
                mem_wdata = {error_attr_reg, CH_ERROR};
            end
            MEM_RD_CELL:
            begin
                mem_re    = 1'b1;
                mem_raddr = pos;
            end
            MEM_RD_SWEEP:
            begin
                mem_re = 1'b1;
            end
            MEM_WR_COPY:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - COLS_A;
                mem_wdata = mem_rdata_reg;
            end
            MEM_WR_ZERO:
            begin
                mem_we = 1'b1;
            end
            MEM_WR_BLANK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {default_attr_reg, CH_BLANK};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            next_col_reg    <= cmd.emit_err ? col_reg : cursor_col_next;
            next_row_reg    <= cmd.emit_err ? row_reg : cursor_row_next;
            coord_error_reg <= cmd.emit_err;
            scrolled_reg    <= cmd.emit_scr;
            cell_char_reg   <= cmd.emit_read ? mem_rdata_reg[CHAR_W-1:0] : '0;
            cell_attr_reg   <= cmd.emit_read ? mem_rdata_reg[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign done        = done_reg;
    assign next_col    = next_col_reg;
    assign next_row    = next_row_reg;
    assign coord_error = coord_error_reg;
    assign scrolled    = scrolled_reg;
    assign cell_char   = cell_char_reg;
    assign cell_attr   = cell_attr_reg;

endmodule

// File: sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-and-attribute text console with cursor, scrolling and clear.
//
//   Channel   Handshake            Payload
//   request   start / busy         func char_code attr col row use_cursor
//   result    done (one cycle)     next_col next_row coord_error scrolled
//                                  cell_char cell_attr
//   config    cfg_we               cfg_addr cfg_wdata
//
// A print without scroll or an invalid coordinate finishes in ST_EXEC; a read adds ST_READ.
// A clear sweeps ST_CLEAR over all COLS*ROWS cells; a print that scrolls alternates
// ST_SCROLL_RD and ST_SCROLL_WR per copied cell, then ST_FILL zeroes the last row.
// The result strobe rises in the cycle after the last state of a request.
// Reset clears cursor and state and presets attributes; the cell store has no reset.
// The receiver cannot stall: each result is flagged by done for one cycle only.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tcw_pkg::FUNC_W-1:0]        func,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]        attr,
    input  logic [tcw_pkg::COL_W-1:0]         col,
    input  logic [tcw_pkg::ROW_W-1:0]         row,
    input  logic                              use_cursor,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [tcw_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              done,
    output logic [tcw_pkg::COL_W-1:0]         next_col,
    output logic [tcw_pkg::ROW_W-1:0]         next_row,
    output logic                              coord_error,
    output logic                              scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]        cell_attr
);
    import tcw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .char_code   (char_code),
        .attr        (attr),
        .col         (col),
        .row         (row),
        .use_cursor  (use_cursor),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .next_col    (next_col),
        .next_row    (next_row),
        .coord_error (coord_error),
        .scrolled    (scrolled),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr)
    );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives print, clear, read and unused requests through the start/busy port.
// A shadow console with its own cells, cursor and attribute registers works
// out every reply. Each done strobe is checked field by field against the
// oldest reply due. Covers cursor and explicit prints, newlines, scrolls,
// off-screen coordinates and register settings at their extremes.
// ----------------------------------------------------------------------------
module tb;

    import tcw_pkg::*;

    localparam int COLS       = DEF_COLS;
    localparam int ROWS       = DEF_ROWS;
    localparam int CELLS      = COLS * ROWS;
    localparam int STALL_MAX  = 40000;
    localparam int PHASE_REQS = 250;

    typedef struct packed {
        func_t               func;
        logic [CHAR_W-1:0]   char_code;
        logic [ATTR_W-1:0]   attr;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic                use_cursor;
    } console_req_t;

    typedef struct packed {
        logic [COL_W-1:0]    next_col;
        logic [ROW_W-1:0]    next_row;
        logic                coord_error;
        logic                scrolled;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
    } console_reply_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic [FUNC_W-1:0]     func       = '0;
    logic [CHAR_W-1:0]     char_code  = '0;
    logic [ATTR_W-1:0]     attr       = '0;
    logic [COL_W-1:0]      col        = '0;
    logic [ROW_W-1:0]      row        = '0;
    logic                  use_cursor = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
    logic [CFG_W-1:0]      cfg_wdata  = '0;
    logic                  busy;
    logic                  done;
    logic [COL_W-1:0]      next_col;
    logic [ROW_W-1:0]      next_row;
    logic                  coord_error;
    logic                  scrolled;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;

    logic [CELL_W-1:0]     shadow_screen [CELLS];
    logic [11:0]           shadow_cursor = '0;
    logic [ATTR_W-1:0]     shadow_default_attr = DEFAULT_ATTR_RST;
    logic [ATTR_W-1:0]     shadow_error_attr   = ERROR_ATTR_RST;
    console_reply_t        console_replies [$];

    bit  quiet_sender   = 1'b0;
    int  mismatch_count = 0;
    int  request_count  = 0;
    int  reply_count    = 0;
    int  scroll_count   = 0;
    int  off_screen_count = 0;
    int  clear_count    = 0;
    int  read_count     = 0;
    int  stall_cycles   = 0;

    text_console_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .char_code(char_code),
        .attr(attr),
        .col(col),
        .row(row),
        .use_cursor(use_cursor),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .next_col(next_col),
        .next_row(next_row),
        .coord_error(coord_error),
        .scrolled(scrolled),
        .cell_char(cell_char),
        .cell_attr(cell_attr)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic console_req_t make_req(func_t f, int ch, int at, int c, int r,
                                              logic uc);
        console_req_t rq;
        rq.func       = f;
        rq.char_code  = CHAR_W'(ch);
        rq.attr       = ATTR_W'(at);
        rq.col        = COL_W'(c);
        rq.row        = ROW_W'(r);
        rq.use_cursor = uc;
        return rq;
    endfunction

    function automatic console_reply_t apply_console_request(console_req_t rq);
        console_reply_t     rep;
        logic [ATTR_W-1:0]  at;
        logic [CELL_W-1:0]  word;
        logic               off_screen;
        int                 pos;
        int                 i;
        rep = '0;
        off_screen = !rq.use_cursor && (int'(rq.col) >= COLS || int'(rq.row) >= ROWS);
        pos = rq.use_cursor ? int'(shadow_cursor) : int'(rq.row) * COLS + int'(rq.col);
        case (rq.func)
            FUNC_PRINT:
            begin
                at = (rq.attr == '0) ? shadow_default_attr : rq.attr;
                if (off_screen)
                begin
                    shadow_screen[CELLS-1] = {shadow_error_attr, CH_ERROR};
                    rep.next_col    = rq.col;
                    rep.next_row    = rq.row;
                    rep.coord_error = 1'b1;
                end
                else
                begin
                    if (rq.char_code == CH_NEWLINE)
                        pos = (pos / COLS + 1) * COLS;
                    else
                    begin
                        shadow_screen[pos] = {at, rq.char_code};
                        pos = pos + 1;
                    end
                    if (pos >= CELLS)
                    begin
                        for (i = 0; i < CELLS - COLS; i++)
                            shadow_screen[i] = shadow_screen[i + COLS];
                        for (i = CELLS - COLS; i < CELLS; i++)
                            shadow_screen[i] = '0;
                        pos = pos - COLS;
                        rep.scrolled = 1'b1;
                    end
                    shadow_cursor = 12'(pos);
                    rep.next_col  = COL_W'(pos % COLS);
                    rep.next_row  = ROW_W'(pos / COLS);
                end
            end
            FUNC_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    shadow_screen[i] = {shadow_default_attr, CH_BLANK};
                shadow_cursor = '0;
            end
            FUNC_READ:
            begin
                if (off_screen)
                begin
                    rep.next_col    = rq.col;
                    rep.next_row    = rq.row;
                    rep.coord_error = 1'b1;
                end
                else
                begin
                    word = shadow_screen[pos];
                    rep.next_col  = COL_W'(int'(shadow_cursor) % COLS);
                    rep.next_row  = ROW_W'(int'(shadow_cursor) / COLS);
                    rep.cell_char = word[CHAR_W-1:0];
                    rep.cell_attr = word[CELL_W-1:CHAR_W];
                end
            end
            default:
            begin
                rep.next_col = COL_W'(int'(shadow_cursor) % COLS);
                rep.next_row = ROW_W'(int'(shadow_cursor) / COLS);
            end
        endcase
        return rep;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet_sender)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(console_req_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= rq.func;
        char_code  <= rq.char_code;
        attr       <= rq.attr;
        col        <= rq.col;
        row        <= rq.row;
        use_cursor <= rq.use_cursor;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        console_replies.push_back(apply_console_request(rq));
        request_count++;
        if (rq.func == FUNC_CLEAR)
            clear_count++;
        if (rq.func == FUNC_READ)
            read_count++;
    endtask

    task automatic set_config(logic [ATTR_W-1:0] dflt, logic [ATTR_W-1:0] err);
        start <= 1'b0;
        @(posedge clk);
        while (console_replies.size() != 0 || busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DEFAULT_ATTR;
        cfg_wdata <= dflt;
        @(posedge clk);
        cfg_addr  <= CFG_ERROR_ATTR;
        cfg_wdata <= err;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_default_attr = dflt;
        shadow_error_attr   = err;
    endtask

    function automatic console_req_t random_request();
        console_req_t rq;
        int roll;
        int ch;
        int at;
        roll = $urandom_range(0, 99);
        ch = ($urandom_range(0, 7) == 0) ? int'(CH_NEWLINE) : $urandom_range(0, 255);
        at = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 255);
        rq = make_req(FUNC_PRINT, ch, at, $urandom_range(0, 127), $urandom_range(0, 31),
                      1'b1);
        if (roll < 38)
            return rq;
        rq.use_cursor = 1'b0;
        if (roll < 63)
        begin
            rq.col = COL_W'($urandom_range(0, COLS - 1));
            rq.row = ROW_W'($urandom_range(0, ROWS - 1));
        end
        else if (roll < 68)
        begin
            rq.row = ROW_W'(ROWS - 1);
            rq.col = $urandom_range(0, 1) ? COL_W'(COLS - 1) : COL_W'($urandom_range(0, COLS - 1));
            rq.char_code = $urandom_range(0, 1) ? CH_NEWLINE : CHAR_W'($urandom_range(0, 255));
        end
        else if (roll < 76 || (roll >= 90 && roll < 94))
        begin
            if (roll >= 90)
                rq.func = FUNC_READ;
            if ($urandom_range(0, 1))
                rq.col = COL_W'($urandom_range(COLS, 127));
            else
                rq.row = ROW_W'($urandom_range(ROWS, 31));
        end
        else if (roll < 90)
        begin
            rq.func       = FUNC_READ;
            rq.use_cursor = 1'($urandom_range(0, 1));
            if (!rq.use_cursor)
            begin
                rq.col = COL_W'($urandom_range(0, COLS - 1));
                rq.row = ROW_W'($urandom_range(0, ROWS - 1));
            end
        end
        else if (roll < 96)
            rq.func = FUNC_CLEAR;
        else if (roll < 98)
        begin
            rq.func       = FUNC_NONE;
            rq.use_cursor = 1'($urandom_range(0, 1));
        end
        else
            rq.use_cursor = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    task automatic test_reset_cursor();
        send_request(make_req(FUNC_PRINT, "A", 0, 127, 31, 1'b1));
        send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 1'b0));
    endtask

    task automatic test_config_extremes();
        set_config(8'h00, 8'hFF);
        send_request(make_req(FUNC_PRINT, "z", 0, 5, 3, 1'b0));
        send_request(make_req(FUNC_PRINT, "q", 0, 127, 31, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, 5, 3, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, COLS - 1, ROWS - 1, 1'b0));
        set_config(8'hFF, 8'h00);
        send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, 127, 31, 1'b1));
        send_request(make_req(FUNC_PRINT, "q", 7, COLS, 0, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, COLS - 1, ROWS - 1, 1'b0));
    endtask

    task automatic test_print_extremes();
        set_config(DEFAULT_ATTR_RST, ERROR_ATTR_RST);
        send_request(make_req(FUNC_PRINT, 0, 255, 0, 0, 1'b0));
        send_request(make_req(FUNC_PRINT, 255, 1, COLS - 1, 0, 1'b0));
        send_request(make_req(FUNC_PRINT, CH_NEWLINE, 0, 0, 0, 1'b1));
        send_request(make_req(FUNC_READ, 0, 0, 0, 0, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, COLS - 1, 0, 1'b0));
        send_request(make_req(FUNC_PRINT, CH_NEWLINE, 0, 7, 4, 1'b0));
    endtask

    task automatic test_coord_errors();
        send_request(make_req(FUNC_READ, 0, 0, COLS, 0, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, 0, ROWS, 1'b0));
        send_request(make_req(FUNC_PRINT, "w", 0, 0, 31, 1'b0));
    endtask

    task automatic test_scroll();
        send_request(make_req(FUNC_PRINT, "x", 8'h1E, 3, ROWS - 1, 1'b0));
        send_request(make_req(FUNC_PRINT, "y", 0, COLS - 1, ROWS - 1, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, 3, ROWS - 2, 1'b0));
        send_request(make_req(FUNC_READ, 0, 0, 0, 0, 1'b1));
        send_request(make_req(FUNC_PRINT, CH_NEWLINE, 0, 0, 0, 1'b1));
    endtask

    task automatic test_unused_func();
        send_request(make_req(FUNC_NONE, 255, 255, 127, 31, 1'b0));
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_config(8'h00, 8'hFF);
                1: set_config(8'hFF, 8'h00);
                2: set_config(ATTR_W'($urandom_range(1, 254)), ATTR_W'($urandom_range(1, 254)));
                default: set_config(DEFAULT_ATTR_RST, ERROR_ATTR_RST);
            endcase
            for (n = 0; n < PHASE_REQS; n++)
            begin
                if (n % 50 == 0)
                    quiet_sender = ($urandom_range(0, 3) == 0);
                send_request(random_request());
            end
            quiet_sender = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, console_reply_t want, console_reply_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb: %s at reply %0d: want col=%0d row=%0d err=%0b scr=%0b ch=%02h at=%02h, got col=%0d row=%0d err=%0b scr=%0b ch=%02h at=%02h",
                     what, reply_count, want.next_col, want.next_row, want.coord_error,
                     want.scrolled, want.cell_char, want.cell_attr, got.next_col, got.next_row,
                     got.coord_error, got.scrolled, got.cell_char, got.cell_attr);
    endtask

    always @(posedge clk)
    begin : check_replies
        console_reply_t got;
        console_reply_t want;
        if (rst_n && done)
        begin
            got = {next_col, next_row, coord_error, scrolled, cell_char, cell_attr};
            if (console_replies.size() == 0)
                report_mismatch("unrequested reply", '0, got);
            else
            begin
                want = console_replies.pop_front();
                if (got.next_col !== want.next_col || got.next_row !== want.next_row ||
                    got.coord_error !== want.coord_error || got.scrolled !== want.scrolled ||
                    got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr)
                    report_mismatch("mismatch", want, got);
            end
            reply_count++;
            if (scrolled === 1'b1)
                scroll_count++;
            if (coord_error === 1'b1)
                off_screen_count++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("tb: watchdog expired, no progress for %0d cycles", STALL_MAX);
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic finish_run();
        start <= 1'b0;
        while (console_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("tb: %0d requests and %0d replies, %0d clears, %0d reads",
                 request_count, reply_count, clear_count, read_count);
        $display("tb: %0d scrolls, %0d off-screen coordinates, %0d mismatches",
                 scroll_count, off_screen_count, mismatch_count);
        if (mismatch_count == 0 && console_replies.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_cursor();
        test_config_extremes();
        test_print_extremes();
        test_coord_errors();
        test_scroll();
        test_unused_func();
        test_random_traffic();
        finish_run();
    end

endmodule
